// ===== rtl/owts_pkg.sv =====
// shared types, constants and helper functions for the 1-wire temperature sensor master
package owts_pkg;

  localparam int DATA_BYTES = 8;
  localparam int KIND_W     = 2;
  localparam int TIMER_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int BYTE_CNT_W = 4;
  localparam int BIT_CNT_W  = 3;
  localparam int TEMP_W     = 16;
  localparam int TENTHS_W   = 12;
  localparam int STATUS_W   = 2;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CONVERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SMPL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_END     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SMPL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_END      = 3'd5;

  localparam logic [TIMER_W-1:0] DEF_RESET_LOW     = 10'd480;
  localparam logic [TIMER_W-1:0] DEF_PRESENCE_SMPL = 10'd550;
  localparam logic [TIMER_W-1:0] DEF_RESET_END     = 10'd960;
  localparam logic [TIMER_W-1:0] DEF_SLOT_LOW      = 10'd2;
  localparam logic [TIMER_W-1:0] DEF_READ_SMPL     = 10'd15;
  localparam logic [TIMER_W-1:0] DEF_SLOT_END      = 10'd60;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_DEVICE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORTED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CRC_ERR   = 2'd3;

  // bus commands
  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT      = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  // reflected dallas crc-8 polynomial
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // byte counter positions within a sequence
  localparam logic [BYTE_CNT_W-1:0] BYTE_ROM   = 4'd0;
  localparam logic [BYTE_CNT_W-1:0] BYTE_FUNC  = 4'd1;
  localparam logic [BYTE_CNT_W-1:0] BYTE_DATA0 = 4'd2;
  localparam logic [BYTE_CNT_W-1:0] BYTE_DATA1 = 4'd3;
  localparam logic [BYTE_CNT_W-1:0] BYTE_CRC   = BYTE_CNT_W'(2 + DATA_BYTES);

  // item queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_TICK,
    OP_CONVERT,
    OP_READ,
    OP_IGNORE
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RESET,
    PH_SLOT,
    PH_RECOVER
  } phase_t;

  typedef struct packed {
    op_t  op;
    logic level;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_slot_t;

  typedef struct packed {
    logic [TIMER_W-1:0] reset_low;
    logic [TIMER_W-1:0] presence_smpl;
    logic [TIMER_W-1:0] reset_end;
    logic [TIMER_W-1:0] slot_low;
    logic [TIMER_W-1:0] read_smpl;
    logic [TIMER_W-1:0] slot_end;
  } cfg_t;

  typedef struct packed {
    logic                       drive_low;
    logic                       busy;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic signed [TENTHS_W-1:0] tenths;
    logic [TEMP_W-1:0]          raw;
  } result_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] d);
    logic [7:0] c;
    logic       t;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      t = c[0] ^ d[i];
      c = {1'b0, c[7:1]} ^ (t ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // sixteenths of a degree to tenths, truncated toward zero
  function automatic logic signed [TENTHS_W-1:0] to_tenths(input logic [11:0] v);
    logic [11:0] m;
    logic [15:0] p;
    logic [11:0] q;
    m = v[11] ? (~v + 12'd1) : v;
    p = ({4'b0, m} << 3) + ({4'b0, m} << 1);
    q = p[15:4];
    return v[11] ? signed'(12'(~q + 12'd1)) : signed'(q);
  endfunction

endpackage

// ===== rtl/owts_if.sv =====
// valid/ready channel interfaces for input items, result items and configuration writes
interface owts_in_if;
  import owts_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              bus_level;
  modport source (output valid, kind, bus_level, input ready);
  modport sink   (input valid, kind, bus_level, output ready);
endinterface

interface owts_out_if;
  import owts_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       drive_low;
  logic                       busy_res;
  logic                       done_res;
  logic [STATUS_W-1:0]        status;
  logic signed [TENTHS_W-1:0] temperature_tenths;
  logic [TEMP_W-1:0]          raw_temperature;
  modport source (output valid, drive_low, busy_res, done_res, status, temperature_tenths,
                  raw_temperature, input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, status, temperature_tenths,
                  raw_temperature, output ready);
endinterface

interface owts_cfg_if;
  import owts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIMER_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/one_wire_temperature_sensor_master_core.sv =====
// 1-wire temperature sensor master: front classifier, item queue, bus sequencer.
// an accepted item is registered in the queue, then in the result register that drives valid;
// throughput: one item per clock unless the output stalls; the sequencer steps once per item.
// the two-entry queue and the result register let input and output stall independently.
// reset (rst_n low at a clock edge) empties the queue, idles the sequencer, clears
// status and temperature and loads the default timing registers; no clearing pass.
module one_wire_temperature_sensor_master_core (
  input  logic       clk,
  input  logic       rst_n,
  owts_in_if.sink    in_ch,
  owts_out_if.source out_ch,
  owts_cfg_if.sink   cfg_ch
);
  import owts_pkg::*;

  q_slot_t push;
  q_slot_t head;
  logic    q_full;
  logic    pop;

  owts_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  owts_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  owts_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/owts_front.sv =====
// front end: accepts input items and classifies them into queue entries
module owts_front (
  owts_in_if.sink         in_ch,
  input  logic            q_full,
  output owts_pkg::q_slot_t push
);
  import owts_pkg::*;

  op_t op;

  always_comb begin
    unique case (in_ch.kind)
      KIND_TICK:    op = OP_TICK;
      KIND_CONVERT: op = OP_CONVERT;
      KIND_READ:    op = OP_READ;
      KIND_UNUSED:  op = OP_IGNORE;
      default:      op = OP_IGNORE;
    endcase
  end

  assign in_ch.ready     = ~q_full;
  assign push.valid      = in_ch.valid & ~q_full;
  assign push.entry.op   = op;
  assign push.entry.level = in_ch.bus_level;

endmodule

// ===== rtl/owts_queue.sv =====
// short fifo of classified items between front and back
module owts_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  owts_pkg::q_slot_t push,
  input  logic              pop,
  output logic              full,
  output owts_pkg::q_slot_t head
);
  import owts_pkg::*;

  q_entry_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign do_push    = push.valid & ~full;
  assign do_pop     = pop & (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

// ===== rtl/owts_back.sv =====
// back end: bus sequencer, timing registers and result register
module owts_back (
  input  logic              clk,
  input  logic              rst_n,
  input  owts_pkg::q_slot_t head,
  output logic              pop,
  owts_cfg_if.sink          cfg_ch,
  owts_out_if.source        out_ch
);
  import owts_pkg::*;

  cfg_t                  cfg_r;
  phase_t                phase_r, phase_nxt;
  logic [TIMER_W-1:0]    timer_r, timer_nxt, timer_inc;
  logic [7:0]            shift_r, shift_nxt;
  logic [BIT_CNT_W-1:0]  bit_r, bit_nxt;
  logic [BYTE_CNT_W-1:0] byte_r, byte_nxt;
  logic [7:0]            crc_r, crc_nxt;
  logic                  presence_r, presence_nxt;
  logic                  is_read_r, is_read_nxt;
  logic [TEMP_W-1:0]     temp_r, temp_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  done_nxt;
  logic                  reading;
  logic                  out_valid_r;
  result_t               res_r, res_nxt;

  assign pop       = head.valid & (~out_valid_r | out_ch.ready);
  assign timer_inc = (timer_r == '1) ? timer_r : timer_r + 1'b1;
  assign reading   = (byte_r >= BYTE_DATA0);

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low     <= DEF_RESET_LOW;
      cfg_r.presence_smpl <= DEF_PRESENCE_SMPL;
      cfg_r.reset_end     <= DEF_RESET_END;
      cfg_r.slot_low      <= DEF_SLOT_LOW;
      cfg_r.read_smpl     <= DEF_READ_SMPL;
      cfg_r.slot_end      <= DEF_SLOT_END;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RESET_LOW:     cfg_r.reset_low     <= cfg_ch.data;
        REG_PRESENCE_SMPL: cfg_r.presence_smpl <= cfg_ch.data;
        REG_RESET_END:     cfg_r.reset_end     <= cfg_ch.data;
        REG_SLOT_LOW:      cfg_r.slot_low      <= cfg_ch.data;
        REG_READ_SMPL:     cfg_r.read_smpl     <= cfg_ch.data;
        REG_SLOT_END:      cfg_r.slot_end      <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // next state of the sequencer for the item at the queue head
  always_comb begin
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    shift_nxt    = shift_r;
    bit_nxt      = bit_r;
    byte_nxt     = byte_r;
    crc_nxt      = crc_r;
    presence_nxt = presence_r;
    is_read_nxt  = is_read_r;
    temp_nxt     = temp_r;
    status_nxt   = status_r;
    done_nxt     = 1'b0;
    unique case (head.entry.op) inside
      OP_CONVERT, OP_READ: begin
        if (phase_r == PH_IDLE) begin
          is_read_nxt  = (head.entry.op == OP_READ);
          presence_nxt = 1'b0;
          if (!head.entry.level) begin
            status_nxt = ST_SHORTED;
            done_nxt   = 1'b1;
          end else begin
            phase_nxt = PH_RESET;
            timer_nxt = '0;
          end
        end
      end
      OP_TICK: begin
        unique case (phase_r)
          PH_RESET: begin
            timer_nxt = timer_inc;
            if (timer_inc == cfg_r.presence_smpl) begin
              presence_nxt = ~head.entry.level;
            end
            if (timer_inc >= cfg_r.reset_end) begin
              if (!presence_nxt) begin
                phase_nxt  = PH_IDLE;
                status_nxt = ST_NO_DEVICE;
                done_nxt   = 1'b1;
              end else begin
                byte_nxt  = BYTE_ROM;
                bit_nxt   = '0;
                shift_nxt = CMD_SKIP_ROM;
                phase_nxt = PH_RECOVER;
              end
            end
          end
          PH_RECOVER: begin
            phase_nxt = PH_SLOT;
            timer_nxt = '0;
            if (reading) begin
              shift_nxt = {1'b0, shift_r[7:1]};
            end
          end
          PH_SLOT: begin
            timer_nxt = timer_inc;
            if (reading && timer_inc == cfg_r.read_smpl) begin
              shift_nxt = {head.entry.level, shift_r[6:0]};
            end
            if (timer_inc >= cfg_r.slot_end) begin
              // end of bit slot
              if (!reading) begin
                shift_nxt = {1'b0, shift_nxt[7:1]};
              end
              bit_nxt   = bit_r + 1'b1;
              phase_nxt = PH_RECOVER;
              if (bit_nxt == '0) begin
                if (byte_r == BYTE_ROM) begin
                  shift_nxt = is_read_r ? CMD_READ_SCRATCH : CMD_CONVERT;
                  byte_nxt  = BYTE_FUNC;
                end else if (byte_r == BYTE_FUNC) begin
                  if (!is_read_r) begin
                    phase_nxt  = PH_IDLE;
                    status_nxt = ST_OK;
                    done_nxt   = 1'b1;
                  end else begin
                    byte_nxt = BYTE_DATA0;
                    crc_nxt  = '0;
                  end
                end else if (byte_r < BYTE_CRC) begin
                  if (byte_r == BYTE_DATA0) begin
                    temp_nxt[7:0] = shift_nxt;
                  end
                  if (byte_r == BYTE_DATA1) begin
                    temp_nxt[15:8] = shift_nxt;
                  end
                  crc_nxt  = crc_byte(crc_r, shift_nxt);
                  byte_nxt = byte_r + 1'b1;
                end else begin
                  phase_nxt  = PH_IDLE;
                  status_nxt = (crc_r == shift_nxt) ? ST_OK : ST_CRC_ERR;
                  done_nxt   = 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result fields from the state after the item
  always_comb begin
    res_nxt.drive_low = 1'b0;
    unique case (phase_nxt)
      PH_RESET: res_nxt.drive_low = (timer_nxt < cfg_r.reset_low);
      PH_SLOT:  res_nxt.drive_low = (timer_nxt < cfg_r.slot_low) ||
                                    (byte_nxt < BYTE_DATA0 && !shift_nxt[0]);
      default:  res_nxt.drive_low = 1'b0;
    endcase
    res_nxt.busy   = (phase_nxt != PH_IDLE);
    res_nxt.done   = done_nxt;
    res_nxt.status = status_nxt;
    res_nxt.tenths = to_tenths(temp_nxt[11:0]);
    res_nxt.raw    = temp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      shift_r     <= '0;
      bit_r       <= '0;
      byte_r      <= '0;
      crc_r       <= '0;
      presence_r  <= 1'b0;
      is_read_r   <= 1'b0;
      temp_r      <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        timer_r     <= timer_nxt;
        shift_r     <= shift_nxt;
        bit_r       <= bit_nxt;
        byte_r      <= byte_nxt;
        crc_r       <= crc_nxt;
        presence_r  <= presence_nxt;
        is_read_r   <= is_read_nxt;
        temp_r      <= temp_nxt;
        status_r    <= status_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.drive_low          = res_r.drive_low;
  assign out_ch.busy_res           = res_r.busy;
  assign out_ch.done_res           = res_r.done;
  assign out_ch.status             = res_r.status;
  assign out_ch.temperature_tenths = res_r.tenths;
  assign out_ch.raw_temperature    = res_r.raw;

endmodule

// ===== dv/one_wire_temperature_sensor_master_core_tb.sv =====
// self-checking testbench for the 1-wire temperature sensor master core
module one_wire_temperature_sensor_master_core_tb;
  import owts_pkg::*;

  localparam int PHASE_ITEMS = 220;

  logic clk;
  logic rst_n;

  owts_in_if  in_ch ();
  owts_out_if out_ch ();
  owts_cfg_if cfg_ch ();

  one_wire_temperature_sensor_master_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // sequencer mirror
  phase_t              seq_phase;
  logic [TIMER_W-1:0]  tmr;
  logic [7:0]          shreg;
  logic [2:0]          bit_cnt;
  logic [3:0]          byte_cnt;
  logic [7:0]          crc_acc;
  logic                presence;
  logic                is_read;
  logic [TEMP_W-1:0]   temp_word;
  logic [STATUS_W-1:0] stat;
  cfg_t                timing;

  // bytes the emulated sensor returns, checksum last
  logic [7:0] scratch [DATA_BYTES+1];

  result_t line_reports_q [$];

  int  in_idle_pct;
  int  out_stall_pct;
  int  hold_req;
  int  hold_left;
  bit  in_held;
  int  n_items;
  int  n_results;
  int  n_fail;
  int  n_cfg;
  int  done_by_status [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] dallas_crc8(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ data[k];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic signed [TENTHS_W-1:0] tenths_of(input logic [11:0] v);
    int s;
    s = int'(signed'(v));
    return TENTHS_W'((s * 10) / 16);
  endfunction

  function automatic result_t advance_sequencer(input logic [KIND_W-1:0] kind,
                                                input logic level);
    result_t r;
    logic    fin;
    logic    drv;
    fin = 1'b0;
    if (kind == KIND_CONVERT || kind == KIND_READ) begin
      // commands only start from idle, otherwise dropped
      if (seq_phase == PH_IDLE) begin
        is_read = (kind == KIND_READ);
        presence = 1'b0;
        if (!level) begin
          fin = 1'b1;
          stat = ST_SHORTED;
        end else begin
          seq_phase = PH_RESET;
          tmr = '0;
        end
      end
    end else if (kind == KIND_TICK) begin
      case (seq_phase)
        PH_RESET: begin
          if (tmr != '1) tmr++;
          if (tmr == timing.presence_smpl) presence = !level;
          if (tmr >= timing.reset_end) begin
            if (!presence) begin
              seq_phase = PH_IDLE;
              stat = ST_NO_DEVICE;
              fin = 1'b1;
            end else begin
              byte_cnt = BYTE_ROM;
              bit_cnt = '0;
              shreg = CMD_SKIP_ROM;
              seq_phase = PH_RECOVER;
            end
          end
        end
        PH_RECOVER: begin
          seq_phase = PH_SLOT;
          tmr = '0;
          if (byte_cnt >= BYTE_DATA0) shreg = shreg >> 1;
        end
        PH_SLOT: begin
          if (tmr != '1) tmr++;
          if (byte_cnt >= BYTE_DATA0 && tmr == timing.read_smpl) shreg[7] = level;
          if (tmr >= timing.slot_end) begin
            if (byte_cnt < BYTE_DATA0) shreg = shreg >> 1;
            bit_cnt++;
            seq_phase = PH_RECOVER;
            if (bit_cnt == '0) begin
              if (byte_cnt == BYTE_ROM) begin
                shreg = is_read ? CMD_READ_SCRATCH : CMD_CONVERT;
                byte_cnt = BYTE_FUNC;
              end else if (byte_cnt == BYTE_FUNC) begin
                if (!is_read) begin
                  seq_phase = PH_IDLE;
                  stat = ST_OK;
                  fin = 1'b1;
                end else begin
                  byte_cnt = BYTE_DATA0;
                  crc_acc = '0;
                end
              end else if (byte_cnt < BYTE_CRC) begin
                if (byte_cnt == BYTE_DATA0) temp_word[7:0] = shreg;
                if (byte_cnt == BYTE_DATA1) temp_word[15:8] = shreg;
                crc_acc = dallas_crc8(crc_acc, shreg);
                byte_cnt++;
              end else begin
                seq_phase = PH_IDLE;
                stat = (crc_acc == shreg) ? ST_OK : ST_CRC_ERR;
                fin = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    drv = 1'b0;
    if (seq_phase == PH_RESET) begin
      drv = tmr < timing.reset_low;
    end else if (seq_phase == PH_SLOT) begin
      drv = (tmr < timing.slot_low) || (byte_cnt < BYTE_DATA0 && !shreg[0]);
    end
    r.drive_low = drv;
    r.busy      = (seq_phase != PH_IDLE);
    r.done      = fin;
    r.status    = stat;
    r.tenths    = tenths_of(temp_word[11:0]);
    r.raw       = temp_word;
    return r;
  endfunction

  // level the sensor puts on the line for the next tick
  function automatic logic line_for_tick(input bit absent);
    logic [TIMER_W-1:0] nxt;
    nxt = (tmr == '1) ? tmr : tmr + 1'b1;
    if (seq_phase == PH_RESET && nxt == timing.presence_smpl) return absent;
    if (seq_phase == PH_SLOT && byte_cnt >= BYTE_DATA0 && nxt == timing.read_smpl)
      return scratch[byte_cnt - BYTE_DATA0][bit_cnt];
    return 1'($urandom_range(1));
  endfunction

  function automatic cfg_t random_timing();
    cfg_t t;
    t.slot_end  = TIMER_W'($urandom_range(1, 5));
    t.read_smpl = TIMER_W'($urandom_range(1, int'(t.slot_end) + 1));
    t.slot_low  = TIMER_W'($urandom_range(1, 3));
    t.reset_end = TIMER_W'($urandom_range(1, 8));
    t.reset_low = TIMER_W'($urandom_range(1, 6));
    if ($urandom_range(9) != 0)
      t.presence_smpl = TIMER_W'($urandom_range(1, int'(t.reset_end)));
    else
      t.presence_smpl = TIMER_W'($urandom_range(1, 12));
    return t;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic level);
    int gap;
    gap = 0;
    while (in_idle_pct > 0 && gap < 20 && $urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0 && in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.bus_level <= level;
    do @(posedge clk); while (!in_ch.ready);
    in_held = 1'b1;
    line_reports_q.push_back(advance_sequencer(kind, level));
    n_items++;
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    if (in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    while (line_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TIMER_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_RESET_LOW:     timing.reset_low     = val;
      REG_PRESENCE_SMPL: timing.presence_smpl = val;
      REG_RESET_END:     timing.reset_end     = val;
      REG_SLOT_LOW:      timing.slot_low      = val;
      REG_READ_SMPL:     timing.read_smpl     = val;
      REG_SLOT_END:      timing.slot_end      = val;
      default: ;
    endcase
    n_cfg++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input cfg_t t);
    settle();
    cfg_write(REG_RESET_LOW,     t.reset_low);
    cfg_write(REG_PRESENCE_SMPL, t.presence_smpl);
    cfg_write(REG_RESET_END,     t.reset_end);
    cfg_write(REG_SLOT_LOW,      t.slot_low);
    cfg_write(REG_READ_SMPL,     t.read_smpl);
    cfg_write(REG_SLOT_END,      t.slot_end);
  endtask

  task automatic finish_sequence(input bit absent, input int noise_pct);
    while (seq_phase != PH_IDLE) begin
      if (noise_pct > 0 && $urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: send_item(KIND_UNUSED, 1'($urandom_range(1)));
          1: send_item($urandom_range(1) ? KIND_READ : KIND_CONVERT, 1'($urandom_range(1)));
          default: send_item(KIND_TICK, 1'($urandom_range(1)));
        endcase
      end else begin
        send_item(KIND_TICK, line_for_tick(absent));
      end
    end
  endtask

  task automatic run_sequence(input logic [KIND_W-1:0] cmd, input logic [15:0] word,
                              input bit absent, input bit bad_crc, input int noise_pct);
    logic [7:0] sum;
    scratch[0] = word[7:0];
    scratch[1] = word[15:8];
    for (int i = 2; i < DATA_BYTES; i++) scratch[i] = 8'($urandom);
    sum = '0;
    for (int i = 0; i < DATA_BYTES; i++) sum = dallas_crc8(sum, scratch[i]);
    if (bad_crc) sum = sum ^ (8'h01 << $urandom_range(7));
    scratch[DATA_BYTES] = sum;
    send_item(cmd, 1'b1);
    finish_sequence(absent, noise_pct);
  endtask

  task automatic test_idle_items();
    send_item(KIND_TICK, 1'b0);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_UNUSED, 1'b0);
    send_item(KIND_UNUSED, 1'b1);
  endtask

  task automatic test_shorted_line();
    send_item(KIND_CONVERT, 1'b0);
    send_item(KIND_READ, 1'b0);
  endtask

  task automatic test_convert();
    set_timing(cfg_t'{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1});
    run_sequence(KIND_CONVERT, 16'h0000, 1'b0, 1'b0, 0);
  endtask

  task automatic test_read_checksum();
    run_sequence(KIND_READ, 16'h0191, 1'b0, 1'b0, 0);
    run_sequence(KIND_READ, 16'hFF5E, 1'b0, 1'b1, 0);
  endtask

  task automatic test_busy_commands();
    send_item(KIND_READ, 1'b1);
    send_item(KIND_CONVERT, 1'b1);
    send_item(KIND_READ, 1'b0);
    send_item(KIND_UNUSED, 1'b0);
    send_item(KIND_TICK, line_for_tick(1'b0));
    send_item(KIND_CONVERT, 1'b0);
    finish_sequence(1'b0, 0);
  endtask

  task automatic test_no_device();
    run_sequence(KIND_READ, 16'h1234, 1'b1, 1'b0, 0);
    // presence point lies past the end of the reset phase
    set_timing(cfg_t'{10'd2, 10'd9, 10'd4, 10'd1, 10'd2, 10'd3});
    run_sequence(KIND_CONVERT, 16'h0000, 1'b0, 1'b0, 0);
    settle();
  endtask

  task automatic test_read_sample_edges();
    set_timing(cfg_t'{10'd1, 10'd1, 10'd1, 10'd1, 10'd0, 10'd2});
    run_sequence(KIND_READ, 16'hFFFF, 1'b0, 1'b0, 0);
    set_timing(cfg_t'{10'd1, 10'd1, 10'd1, 10'd1, 10'd5, 10'd3});
    run_sequence(KIND_READ, 16'hA5A5, 1'b0, 1'b0, 0);
    settle();
  endtask

  task automatic test_temperature_extremes();
    logic [15:0] words [8];
    words = '{16'h07FF, 16'h0800, 16'hFFFF, 16'h0000, 16'hFFF0, 16'h0191, 16'hFF5E,
              16'hA7FF};
    set_timing(cfg_t'{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1});
    foreach (words[i]) run_sequence(KIND_READ, words[i], 1'b0, 1'b0, 0);
    settle();
  endtask

  task automatic test_backpressure();
    set_timing(cfg_t'{10'd3, 10'd4, 10'd5, 10'd2, 10'd3, 10'd4});
    hold_req = 300;
    run_sequence(KIND_CONVERT, 16'h0000, 1'b0, 1'b0, 0);
    settle();
  endtask

  task automatic test_timing_extremes();
    set_timing(cfg_t'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023});
    run_sequence(KIND_CONVERT, 16'h0000, 1'b0, 1'b0, 0);
    set_timing(cfg_t'{DEF_RESET_LOW, DEF_PRESENCE_SMPL, DEF_RESET_END, DEF_SLOT_LOW,
                      DEF_READ_SMPL, DEF_SLOT_END});
    run_sequence(KIND_READ, 16'h0550, 1'b0, 1'b0, 0);
    settle();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int start;
    int pick;
    settle();
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    set_timing(random_timing());
    start = n_items;
    while (n_items - start < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_item(KIND_TICK, 1'($urandom_range(1)));
      end else if (pick < 10) begin
        send_item(KIND_UNUSED, 1'($urandom_range(1)));
      end else if (pick < 15) begin
        send_item($urandom_range(1) ? KIND_READ : KIND_CONVERT, 1'b0);
      end else if (pick < 20) begin
        set_timing(random_timing());
      end else begin
        run_sequence($urandom_range(1) ? KIND_READ : KIND_CONVERT, 16'($urandom),
                     $urandom_range(99) < 8, $urandom_range(99) < 15,
                     ($urandom_range(3) == 0) ? 4 : 0);
      end
    end
    settle();
  endtask

  task automatic field_diff(input string name, input logic signed [31:0] want_v,
                            input logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      n_fail++;
    end
  endtask

  // result side: random stalls, long hold-off on request
  initial begin
    result_t want;
    out_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
        if (line_reports_q.size() == 0) begin
          $error("result item arrived with nothing expected");
          n_fail++;
        end else begin
          want = line_reports_q.pop_front();
          n_results++;
          if (want.done) done_by_status[want.status]++;
          field_diff("drive_low", want.drive_low, out_ch.drive_low);
          field_diff("busy_res", want.busy, out_ch.busy_res);
          field_diff("done_res", want.done, out_ch.done_res);
          field_diff("status", want.status, out_ch.status);
          field_diff("temperature_tenths", want.tenths, out_ch.temperature_tenths);
          field_diff("raw_temperature", want.raw, out_ch.raw_temperature);
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_TICK;
    in_ch.bus_level <= 1'b1;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_RESET_LOW;
    cfg_ch.data     <= '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req = 0;
    in_held = 1'b0;
    n_items = 0;
    n_results = 0;
    n_fail = 0;
    n_cfg = 0;
    foreach (done_by_status[i]) done_by_status[i] = 0;
    foreach (scratch[i]) scratch[i] = '0;
    seq_phase = PH_IDLE;
    tmr       = '0;
    shreg     = '0;
    bit_cnt   = '0;
    byte_cnt  = '0;
    crc_acc   = '0;
    presence  = 1'b0;
    is_read   = 1'b0;
    temp_word = '0;
    stat      = ST_OK;
    timing    = cfg_t'{DEF_RESET_LOW, DEF_PRESENCE_SMPL, DEF_RESET_END, DEF_SLOT_LOW,
                       DEF_READ_SMPL, DEF_SLOT_END};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_items();
    test_shorted_line();
    test_convert();
    test_read_checksum();
    test_busy_commands();
    test_no_device();
    test_read_sample_edges();
    test_temperature_extremes();
    test_backpressure();
    test_timing_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(65, 0);
    test_random_traffic(0, 65);
    test_random_traffic(20, 20);

    settle();
    repeat (10) @(posedge clk);
    $display("sent %0d items and %0d register writes, checked %0d results",
             n_items, n_cfg, n_results);
    $display("sequences ended: ok %0d, no device %0d, shorted %0d, checksum error %0d",
             done_by_status[ST_OK], done_by_status[ST_NO_DEVICE],
             done_by_status[ST_SHORTED], done_by_status[ST_CRC_ERR]);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
